### hdl/gcib_pkg.sv
`default_nettype none

package gcib_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int TBL_LEN = 32;

    // Angle word: degrees with 40 fraction bits.
    localparam int ZW = 52;
    // Sine and cosine word: 30 fraction bits.
    localparam int SCW = 34;
    // Products and the vectoring datapath: 60 fraction bits.
    localparam int VW = 64;
    localparam int BW = ZW - 17;

    localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
    localparam logic signed [SCW-1:0] KGAIN = SCW'(64'h26DD3B6A);

    localparam logic signed [ZW-1:0] DEG45 = ZW'(64'd45 << 40);
    localparam logic signed [ZW-1:0] DEG90 = ZW'(64'd90 << 40);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(64'd180 << 40);
    localparam logic signed [ZW-1:0] DEG360 = ZW'(64'd360 << 40);
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(64'd65536);

    localparam logic signed [33:0] FULL_Q23 = 34'sd3019898880;
    localparam logic signed [33:0] HALF_Q23 = 34'sd1509949440;

    localparam logic signed [30:0] STATION_LAT_RST = 31'sd245813897;
    localparam logic signed [31:0] STATION_LON_RST = -32'sd680422644;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STATION_LATITUDE,
        REG_STATION_LONGITUDE
    } cfg_reg_t;

    // Arctangent of 2^-idx in degrees with 40 fraction bits, from the
    // alternating series in 60-bit radians with every term truncated.
    function automatic logic signed [ZW-1:0] atan_deg40(input int idx);
        logic [63:0] sum;
        logic [63:0] term;
        logic [127:0] prod;
        int n;
        int sh;
        if (idx == 0) begin
            return DEG45;
        end
        sum = 64'd0;
        for (n = 0; n < 31; n++) begin
            sh = idx * (2 * n + 1);
            if (sh < 61) begin
                term = (64'd1 << 60) >> sh;
                term = term / 64'(2 * n + 1);
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        prod = 128'(sum) * (128'd180 << 40);
        prod = prod / 128'(PI60);
        return prod[ZW-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/gcib_rot_cell.sv
`default_nettype none

module gcib_rot_cell #(
    parameter int XW = gcib_pkg::SCW,
    parameter int IDX = 0
) (
    input  wire                             aclk,
    input  wire                             en,
    input  wire logic signed [XW-1:0]       x_i,
    input  wire logic signed [XW-1:0]       y_i,
    input  wire logic signed [gcib_pkg::ZW-1:0] z_i,
    output logic signed [XW-1:0]            x_o,
    output logic signed [XW-1:0]            y_o,
    output logic signed [gcib_pkg::ZW-1:0]  z_o
);

    localparam logic signed [gcib_pkg::ZW-1:0] ATAN = gcib_pkg::atan_deg40(IDX);

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [gcib_pkg::ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] dx, dy;

    always_comb begin
        dx = y_i >>> IDX;
        dy = x_i >>> IDX;
        if (z_i >= 0) begin
            x_next = x_i - dx;
            y_next = y_i + dy;
            z_next = z_i - ATAN;
        end else begin
            x_next = x_i + dx;
            y_next = y_i - dy;
            z_next = z_i + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;

endmodule

`default_nettype wire

### hdl/gcib_vec_cell.sv
`default_nettype none

module gcib_vec_cell #(
    parameter int XW = gcib_pkg::VW,
    parameter int IDX = 0
) (
    input  wire                             aclk,
    input  wire                             en,
    input  wire logic signed [XW-1:0]       x_i,
    input  wire logic signed [XW-1:0]       y_i,
    input  wire logic signed [gcib_pkg::ZW-1:0] z_i,
    output logic signed [XW-1:0]            x_o,
    output logic signed [XW-1:0]            y_o,
    output logic signed [gcib_pkg::ZW-1:0]  z_o
);

    localparam logic signed [gcib_pkg::ZW-1:0] ATAN = gcib_pkg::atan_deg40(IDX);

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [gcib_pkg::ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] dx, dy;

    always_comb begin
        dx = y_i >>> IDX;
        dy = x_i >>> IDX;
        if (y_i >= 0) begin
            x_next = x_i + dx;
            y_next = y_i - dy;
            z_next = z_i + ATAN;
        end else begin
            x_next = x_i - dx;
            y_next = y_i + dy;
            z_next = z_i - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;

endmodule

`default_nettype wire

### hdl/gcib_sincos.sv
`default_nettype none

module gcib_sincos #(
    parameter int STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                  aclk,
    input  wire                                  en,
    input  wire logic signed [gcib_pkg::ZW-1:0]  angle_i,
    output logic signed [gcib_pkg::SCW-1:0]      cos_o,
    output logic signed [gcib_pkg::SCW-1:0]      sin_o
);

    localparam int XW = gcib_pkg::SCW;
    localparam int ZW = gcib_pkg::ZW;

    logic signed [ZW-1:0] zf_reg, zf_next;
    logic negf_reg, negf_next;
    logic neg_pipe_reg [STAGES];
    logic signed [XW-1:0] x_w [STAGES+1];
    logic signed [XW-1:0] y_w [STAGES+1];
    logic signed [ZW-1:0] z_w [STAGES+1];
    logic signed [XW-1:0] cos_reg, sin_reg;

    // Angles beyond a quarter turn are moved by a half turn and the result negated.
    always_comb begin
        zf_next = angle_i;
        negf_next = 1'b0;
        if (angle_i > gcib_pkg::DEG90) begin
            zf_next = angle_i - gcib_pkg::DEG180;
            negf_next = 1'b1;
        end else if (angle_i < -gcib_pkg::DEG90) begin
            zf_next = angle_i + gcib_pkg::DEG180;
            negf_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zf_reg <= zf_next;
            negf_reg <= negf_next;
            neg_pipe_reg[0] <= negf_reg;
            for (int k = 1; k < STAGES; k++) begin
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
            end
            cos_reg <= neg_pipe_reg[STAGES-1] ? -x_w[STAGES] : x_w[STAGES];
            sin_reg <= neg_pipe_reg[STAGES-1] ? -y_w[STAGES] : y_w[STAGES];
        end
    end

    assign x_w[0] = gcib_pkg::KGAIN;
    assign y_w[0] = '0;
    assign z_w[0] = zf_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        gcib_rot_cell #(
            .XW (XW),
            .IDX(i)
        ) u_cell (
            .aclk(aclk),
            .en  (en),
            .x_i (x_w[i]),
            .y_i (y_w[i]),
            .z_i (z_w[i]),
            .x_o (x_w[i+1]),
            .y_o (y_w[i+1]),
            .z_o (z_w[i+1])
        );
    end

    assign cos_o = cos_reg;
    assign sin_o = sin_reg;

endmodule

`default_nettype wire

### hdl/great_circle_initial_bearing_core.sv
// Initial great-circle bearing from a configured ground station to a position fix.
// Input channel s_*: one item holds a target latitude and longitude, degrees
// times 2^23, two's complement. Result channel m_*: one item holds the bearing,
// degrees times 2^23, from 0 to under 360. Both channels use valid and ready.
// The station position must be written through the cfg_* port only while the block
// is idle; the block itself does not enforce this. The datapath is a row of CORDIC
// cells: a front stage, three sine and cosine rows of CORDIC_STAGES + 2 cells, three
// multiply stages, a quadrant stage, a vectoring row of CORDIC_STAGES cells, a fold
// stage and the output register. One item is accepted every cycle while s_ready is
// high; every cell moves its data on in each cycle that the pipeline is enabled.
// A point equal to the station, or a vector with both parts zero, gives 0.
// When the receiver stalls, the output register holds its item and one more
// item lands in a skid register; only then is s_ready dropped and the whole
// row held in place. Reset clears all valid flags and loads the default station.
`default_nettype none

module great_circle_initial_bearing_core #(
    parameter int CORDIC_STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire logic signed [30:0]                s_point_latitude,
    input  wire logic signed [31:0]                s_point_longitude,
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic [31:0]                            m_bearing,
    input  wire                                    cfg_wr_en,
    input  wire logic [gcib_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [31:0]                       cfg_wr_data
);

    localparam int ZW = gcib_pkg::ZW;
    localparam int SCW = gcib_pkg::SCW;
    localparam int VW = gcib_pkg::VW;
    localparam int BW = gcib_pkg::BW;
    localparam int TOTAL = 2 * CORDIC_STAGES + 8;
    localparam int EQ_LEN = CORDIC_STAGES + 6;

    logic signed [30:0] station_lat_reg;
    logic signed [31:0] station_lon_reg;

    logic en;
    logic vld_reg [TOTAL];
    logic eq_pipe_reg [EQ_LEN];
    logic zero_v0_reg;
    logic zero_pipe_reg [CORDIC_STAGES];

    logic signed [32:0] dlon_raw;
    logic signed [33:0] dlon_wide, dlon_red;
    logic eq_in;

    logic signed [30:0] plat_reg;
    logic signed [30:0] slat_reg;
    logic signed [31:0] dlon_reg;
    logic signed [ZW-1:0] slat_ang, plat_ang, dlon_ang;

    logic signed [SCW-1:0] c1, s1, c2, s2, cd, sd;

    logic signed [2*SCW-1:0] prod_y, prod_cc, prod_cs, prod_m;
    logic signed [VW-1:0] yv1_reg, p1_reg, p2_1_reg;
    logic signed [SCW-1:0] s1_1_reg;
    logic signed [VW-1:0] c2cd_full;
    logic signed [SCW-1:0] c2cd;
    logic signed [VW-1:0] m2_reg, yv2_reg, p2_2_reg;
    logic signed [VW-1:0] xv3_reg, yv3_reg;

    logic signed [VW-1:0] x0_next, y0_next;
    logic signed [ZW-1:0] z0_next;
    logic zero_v0_next;

    logic signed [VW-1:0] vx_w [CORDIC_STAGES+1];
    logic signed [VW-1:0] vy_w [CORDIC_STAGES+1];
    logic signed [ZW-1:0] vz_w [CORDIC_STAGES+1];

    logic signed [ZW-1:0] z_pos, z_rnd;
    logic signed [BW-1:0] b_raw, b_adj;
    logic [31:0] res_reg, res_next;

    logic m_valid_reg, m_valid_next;
    logic [31:0] m_bearing_reg, m_bearing_next;
    logic skid_vld_reg, skid_vld_next;
    logic [31:0] skid_reg, skid_next;
    logic incoming;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_lat_reg <= gcib_pkg::STATION_LAT_RST;
            station_lon_reg <= gcib_pkg::STATION_LON_RST;
        end else if (cfg_wr_en) begin
            case (gcib_pkg::cfg_reg_t'(cfg_addr))
                gcib_pkg::REG_STATION_LATITUDE: begin
                    station_lat_reg <= cfg_wr_data[30:0];
                end
                gcib_pkg::REG_STATION_LONGITUDE: begin
                    station_lon_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign en = !skid_vld_reg;
    assign s_ready = en;

    // The longitude difference is brought into the half-open range of one turn.
    always_comb begin
        dlon_raw = {s_point_longitude[31], s_point_longitude}
                 - {station_lon_reg[31], station_lon_reg};
        dlon_wide = {dlon_raw[32], dlon_raw};
        if (dlon_wide >= gcib_pkg::HALF_Q23) begin
            dlon_red = dlon_wide - gcib_pkg::FULL_Q23;
        end else if (dlon_wide < -gcib_pkg::HALF_Q23) begin
            dlon_red = dlon_wide + gcib_pkg::FULL_Q23;
        end else begin
            dlon_red = dlon_wide;
        end
        eq_in = (s_point_latitude == station_lat_reg)
             && (s_point_longitude == station_lon_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TOTAL; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < TOTAL; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plat_reg <= s_point_latitude;
            slat_reg <= station_lat_reg;
            dlon_reg <= dlon_red[31:0];
            eq_pipe_reg[0] <= eq_in;
            for (int k = 1; k < EQ_LEN; k++) begin
                eq_pipe_reg[k] <= eq_pipe_reg[k-1];
            end
        end
    end

    assign slat_ang = {{(ZW-48){slat_reg[30]}}, slat_reg, 17'b0};
    assign plat_ang = {{(ZW-48){plat_reg[30]}}, plat_reg, 17'b0};
    assign dlon_ang = {{(ZW-49){dlon_reg[31]}}, dlon_reg, 17'b0};

    gcib_sincos #(.STAGES(CORDIC_STAGES)) u_sc_station (
        .aclk(aclk), .en(en), .angle_i(slat_ang), .cos_o(c1), .sin_o(s1)
    );

    gcib_sincos #(.STAGES(CORDIC_STAGES)) u_sc_point (
        .aclk(aclk), .en(en), .angle_i(plat_ang), .cos_o(c2), .sin_o(s2)
    );

    gcib_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
        .aclk(aclk), .en(en), .angle_i(dlon_ang), .cos_o(cd), .sin_o(sd)
    );

    assign prod_y = sd * c2;
    assign prod_cc = c2 * cd;
    assign prod_cs = c1 * s2;
    assign c2cd_full = p1_reg >>> 30;
    assign c2cd = c2cd_full[SCW-1:0];
    assign prod_m = s1_1_reg * c2cd;

    always_ff @(posedge aclk) begin
        if (en) begin
            yv1_reg <= prod_y[VW-1:0];
            p1_reg <= prod_cc[VW-1:0];
            p2_1_reg <= prod_cs[VW-1:0];
            s1_1_reg <= s1;
            m2_reg <= prod_m[VW-1:0];
            yv2_reg <= yv1_reg;
            p2_2_reg <= p2_1_reg;
            xv3_reg <= p2_2_reg - m2_reg;
            yv3_reg <= yv2_reg;
        end
    end

    // A vector in the left half plane is turned by a half turn first.
    always_comb begin
        zero_v0_next = eq_pipe_reg[EQ_LEN-1] || ((xv3_reg == '0) && (yv3_reg == '0));
        if (xv3_reg < 0) begin
            x0_next = -xv3_reg;
            y0_next = -yv3_reg;
            z0_next = (yv3_reg >= 0) ? gcib_pkg::DEG180 : -gcib_pkg::DEG180;
        end else begin
            x0_next = xv3_reg;
            y0_next = yv3_reg;
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_w[0] <= x0_next;
            vy_w[0] <= y0_next;
            vz_w[0] <= z0_next;
            zero_v0_reg <= zero_v0_next;
            zero_pipe_reg[0] <= zero_v0_reg;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                zero_pipe_reg[k] <= zero_pipe_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
        gcib_vec_cell #(
            .XW (VW),
            .IDX(i)
        ) u_cell (
            .aclk(aclk),
            .en  (en),
            .x_i (vx_w[i]),
            .y_i (vy_w[i]),
            .z_i (vz_w[i]),
            .x_o (vx_w[i+1]),
            .y_o (vy_w[i+1]),
            .z_o (vz_w[i+1])
        );
    end

    always_comb begin
        z_pos = (vz_w[CORDIC_STAGES] < 0) ? vz_w[CORDIC_STAGES] + gcib_pkg::DEG360
                                          : vz_w[CORDIC_STAGES];
        z_rnd = z_pos + gcib_pkg::ROUND_HALF;
        b_raw = z_rnd[ZW-1:17];
        if (b_raw >= BW'(gcib_pkg::FULL_Q23)) begin
            b_adj = b_raw - BW'(gcib_pkg::FULL_Q23);
        end else if (b_raw < 0) begin
            b_adj = '0;
        end else begin
            b_adj = b_raw;
        end
        res_next = zero_pipe_reg[CORDIC_STAGES-1] ? 32'd0 : b_adj[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign incoming = en && vld_reg[TOTAL-1];

    always_comb begin
        m_valid_next = m_valid_reg;
        m_bearing_next = m_bearing_reg;
        skid_vld_next = skid_vld_reg;
        skid_next = skid_reg;
        if (m_valid_reg && !m_ready) begin
            if (incoming) begin
                skid_vld_next = 1'b1;
                skid_next = res_reg;
            end
        end else if (skid_vld_reg) begin
            m_valid_next = 1'b1;
            m_bearing_next = skid_reg;
            skid_vld_next = 1'b0;
        end else if (incoming) begin
            m_valid_next = 1'b1;
            m_bearing_next = res_reg;
        end else begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            skid_vld_reg <= skid_vld_next;
        end
        m_bearing_reg <= m_bearing_next;
        skid_reg <= skid_next;
    end

    assign m_valid = m_valid_reg;
    assign m_bearing = m_bearing_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("Skid register holds an item while the output register is empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("Skid register filled without a stalled output.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({2'b00, m_bearing_reg} < gcib_pkg::FULL_Q23))
        else $error("Bearing reached a full turn.");

    assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_valid_reg && !skid_vld_reg))
        else $error("Output side not empty after reset.");

endmodule

`default_nettype wire
